>>> sv/tar_hcc_pkg.sv
// Package for the tar header checksum checker.
// Holds the payload types, status codes and octal parser phase codes.
// No dependencies; design files use scoped names, the testbench imports it.
`default_nettype none

package tar_hcc_pkg;

    // Header geometry.
    localparam int unsigned BlockBytes = 512;
    localparam int unsigned PosWidth   = $clog2(BlockBytes);
    localparam logic [PosWidth-1:0] LastPos = PosWidth'(BlockBytes - 1);
    localparam logic [PosWidth-1:0] CkFirst = PosWidth'(148);
    localparam logic [PosWidth-1:0] CkLast  = PosWidth'(148 + 8 - 1);

    // Field widths.
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned SumWidth  = 17;
    localparam int unsigned CkWidth   = 24;

    // Byte value that the checksum field counts as, and that the parser skips.
    localparam logic [ByteWidth-1:0] SpaceByte = 8'h20;

    // Result status codes.
    localparam logic [1:0] StatusValid    = 2'd0;
    localparam logic [1:0] StatusEndOfArc = 2'd1;
    localparam logic [1:0] StatusLeadNul  = 2'd2;
    localparam logic [1:0] StatusMismatch = 2'd3;

    // Octal parser phases; the fourth code behaves as stopped.
    localparam logic [1:0] PhaseSkip   = 2'd0;
    localparam logic [1:0] PhaseDigits = 2'd1;
    localparam logic [1:0] PhaseStop   = 2'd2;

    // One header byte as held in the input register.
    typedef struct packed {
        logic [ByteWidth-1:0] header_byte;
        logic                 block_start;
    } byte_item_t;

    // One result item as held in the result register.
    typedef struct packed {
        logic [1:0]          status;
        logic [SumWidth-1:0] computed_sum;
        logic [CkWidth-1:0]  stored_checksum;
    } result_item_t;

endpackage

`default_nettype wire

>>> sv/tar_hcc_byte_if.sv
// Stream interface for header bytes entering the checker.
// Carries valid, ready and the byte payload; depends on tar_hcc_pkg.
`default_nettype none

interface tar_hcc_byte_if;
    logic                                 valid;
    logic                                 ready;
    logic [tar_hcc_pkg::ByteWidth-1:0]    header_byte;
    logic                                 block_start;

    modport source (output valid, output header_byte, output block_start, input ready);
    modport sink   (input valid, input header_byte, input block_start, output ready);
    modport monitor (input valid, input ready, input header_byte, input block_start);
endinterface

`default_nettype wire

>>> sv/tar_hcc_result_if.sv
// Stream interface for checksum results leaving the checker.
// Carries valid, ready and the result payload; depends on tar_hcc_pkg.
`default_nettype none

interface tar_hcc_result_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic [tar_hcc_pkg::SumWidth-1:0]    computed_sum;
    logic [tar_hcc_pkg::CkWidth-1:0]     stored_checksum;

    modport source (output valid, output status, output computed_sum,
                    output stored_checksum, input ready);
    modport sink   (input valid, input status, input computed_sum,
                    input stored_checksum, output ready);
    modport monitor (input valid, input ready, input status, input computed_sum,
                     input stored_checksum);
endinterface

`default_nettype wire

>>> sv/tar_hcc_in_stage.sv
// Input register of the checker: captures one byte per transfer.
// Depends on tar_hcc_pkg and tar_hcc_byte_if.
`default_nettype none

module tar_hcc_in_stage (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    tar_hcc_byte_if.sink                 hdr,
    input  wire logic                    adv,
    output tar_hcc_pkg::byte_item_t      item,
    output logic                         item_valid
);

    logic                    valid_reg;
    logic                    valid_next;
    tar_hcc_pkg::byte_item_t item_reg;

    // A new byte may enter when the register is empty or drains this cycle.
    assign hdr.ready = !valid_reg || adv;

    always_comb
    begin
        valid_next = valid_reg;
        if (hdr.ready)
        begin
            valid_next = hdr.valid;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, loaded on every transfer.
    always_ff @(posedge clk)
    begin
        if (hdr.valid && hdr.ready)
        begin
            item_reg.header_byte <= hdr.header_byte;
            item_reg.block_start <= hdr.block_start;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

>>> sv/tar_hcc_accum.sv
// Block state of the checker (position, sum, octal parser, NUL flags)
// and the result register filled after the last byte of a header.
// Depends on tar_hcc_pkg.
`default_nettype none

module tar_hcc_accum (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tar_hcc_pkg::byte_item_t     item,
    input  wire logic                        item_valid,
    output logic                             adv,
    output tar_hcc_pkg::result_item_t        res,
    output logic                             res_valid,
    input  wire logic                        res_ready
);

    localparam int unsigned PW = tar_hcc_pkg::PosWidth;
    localparam int unsigned SW = tar_hcc_pkg::SumWidth;
    localparam int unsigned CW = tar_hcc_pkg::CkWidth;

    logic [PW-1:0] pos_reg, pos_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0] ck_reg, ck_next;
    logic [1:0]    phase_reg, phase_next;
    logic          fnul_reg, fnul_next;
    logic          azero_reg, azero_next;
    logic          out_valid_reg, out_valid_next;
    tar_hcc_pkg::result_item_t out_reg;
    tar_hcc_pkg::result_item_t out_next;

    // Block state as seen by this byte, after a start mark clears it.
    logic [PW-1:0] pos_eff;
    logic [SW-1:0] sum_eff;
    logic [CW-1:0] ck_eff;
    logic [1:0]    phase_eff;
    logic          fnul_eff;
    logic          azero_eff;

    // Values after this byte.
    logic [SW-1:0] sum_upd;
    logic [CW-1:0] ck_upd;
    logic [1:0]    phase_upd;
    logic          fnul_upd;
    logic          azero_upd;

    logic [7:0] b;
    logic       is_digit;
    logic       in_field;
    logic       is_last;
    logic       out_free;

    assign b         = item.header_byte;
    assign pos_eff   = item.block_start ? '0 : pos_reg;
    assign sum_eff   = item.block_start ? '0 : sum_reg;
    assign ck_eff    = item.block_start ? '0 : ck_reg;
    assign phase_eff = item.block_start ? tar_hcc_pkg::PhaseSkip : phase_reg;
    assign fnul_eff  = item.block_start ? 1'b0 : fnul_reg;
    assign azero_eff = item.block_start ? 1'b1 : azero_reg;

    assign is_digit = (b[7:3] == 5'b00110);
    assign in_field = (pos_eff >= tar_hcc_pkg::CkFirst) && (pos_eff <= tar_hcc_pkg::CkLast);
    assign is_last  = (pos_eff == tar_hcc_pkg::LastPos);

    // The result register can take a new result when empty or being read.
    assign out_free = !out_valid_reg || res_ready;
    assign adv      = item_valid && (!is_last || out_free);

    // Sum and NUL tracking; the checksum field counts as spaces.
    always_comb
    begin
        fnul_upd  = (pos_eff == '0) ? (b == 8'h00) : fnul_eff;
        azero_upd = azero_eff && (b == 8'h00);
        if (in_field)
        begin
            sum_upd = sum_eff + SW'(tar_hcc_pkg::SpaceByte);
        end
        else
        begin
            sum_upd = sum_eff + SW'(b);
        end
    end

    // Octal parse of the checksum field, one character per byte.
    always_comb
    begin
        ck_upd    = ck_eff;
        phase_upd = phase_eff;
        if (in_field)
        begin
            case (phase_eff)
                tar_hcc_pkg::PhaseSkip:
                begin
                    if (b == tar_hcc_pkg::SpaceByte)
                    begin
                        phase_upd = phase_eff;
                    end
                    else if (is_digit)
                    begin
                        ck_upd    = CW'(b[2:0]);
                        phase_upd = tar_hcc_pkg::PhaseDigits;
                    end
                    else
                    begin
                        phase_upd = tar_hcc_pkg::PhaseStop;
                    end
                end
                tar_hcc_pkg::PhaseDigits:
                begin
                    if (is_digit)
                    begin
                        ck_upd = {ck_eff[CW-4:0], b[2:0]};
                    end
                    else
                    begin
                        phase_upd = tar_hcc_pkg::PhaseStop;
                    end
                end
                default:
                begin
                    phase_upd = phase_eff;
                end
            endcase
        end
    end

    // Next block state and result register contents.
    always_comb
    begin
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        ck_next        = ck_reg;
        phase_next     = phase_reg;
        fnul_next      = fnul_reg;
        azero_next     = azero_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;
        if (adv)
        begin
            if (is_last)
            begin
                pos_next       = '0;
                sum_next       = '0;
                ck_next        = '0;
                phase_next     = tar_hcc_pkg::PhaseSkip;
                fnul_next      = 1'b0;
                azero_next     = 1'b1;
                out_valid_next = 1'b1;
                if (azero_upd)
                begin
                    out_next.status = tar_hcc_pkg::StatusEndOfArc;
                end
                else if (fnul_upd)
                begin
                    out_next.status = tar_hcc_pkg::StatusLeadNul;
                end
                else if (ck_upd != CW'(sum_upd))
                begin
                    out_next.status = tar_hcc_pkg::StatusMismatch;
                end
                else
                begin
                    out_next.status = tar_hcc_pkg::StatusValid;
                end
                out_next.computed_sum    = sum_upd;
                out_next.stored_checksum = ck_upd;
            end
            else
            begin
                pos_next   = pos_eff + PW'(1);
                sum_next   = sum_upd;
                ck_next    = ck_upd;
                phase_next = phase_upd;
                fnul_next  = fnul_upd;
                azero_next = azero_upd;
            end
        end
    end

    // Control and block state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sum_reg       <= '0;
            ck_reg        <= '0;
            phase_reg     <= tar_hcc_pkg::PhaseSkip;
            fnul_reg      <= 1'b0;
            azero_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            ck_reg        <= ck_next;
            phase_reg     <= phase_next;
            fnul_reg      <= fnul_next;
            azero_reg     <= azero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res       = out_reg;
    assign res_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> sv/tar_header_checksum_check_top.sv
// Tar header checksum checker: takes one header byte per transfer.
// The result register offers a result once byte 511 leaves the input register.
// One byte per cycle unless stalled; sum and octal update are combinational.
// A waiting result stalls input only when the next byte would end a block.
// Reset clears the position, sum, parser and the pending result at once.
// Depends on tar_hcc_pkg, tar_hcc_byte_if, tar_hcc_result_if and submodules.
`default_nettype none

module tar_header_checksum_check_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    tar_hcc_byte_if.sink      hdr,
    tar_hcc_result_if.source  result
);

    tar_hcc_pkg::byte_item_t   item;
    tar_hcc_pkg::result_item_t res;
    logic                      item_valid;
    logic                      adv;
    logic                      res_valid;

    // Input register.
    tar_hcc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .hdr        (hdr),
        .adv        (adv),
        .item       (item),
        .item_valid (item_valid)
    );

    // Block state and result register.
    tar_hcc_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .adv        (adv),
        .res        (res),
        .res_valid  (res_valid),
        .res_ready  (result.ready)
    );

    // Drive the result channel.
    assign result.valid           = res_valid;
    assign result.status          = res.status;
    assign result.computed_sum    = res.computed_sum;
    assign result.stored_checksum = res.stored_checksum;

endmodule

`default_nettype wire

>>> sv/tar_hcc_checker.sv
// Port-level assertions for the tar header checksum checker, bound to the top.
// Depends on tar_hcc_pkg and tar_hcc_result_if.
`default_nettype none

module tar_hcc_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    tar_hcc_result_if.source    res
);

    // A result waiting for transfer stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid)
        else $error("result valid dropped before transfer");

    // A valid header has a matching sum and checksum.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status == tar_hcc_pkg::StatusValid
        |-> res.computed_sum == 17'(res.stored_checksum) && res.stored_checksum[23:17] == 7'd0)
        else $error("valid status with differing sums");

    // An all-zero block sums to eight spaces and parses no digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status == tar_hcc_pkg::StatusEndOfArc
        |-> res.computed_sum == 17'd256 && res.stored_checksum == 24'd0)
        else $error("end of archive with nonzero content");

    // A mismatch really differs.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status == tar_hcc_pkg::StatusMismatch
        |-> res.stored_checksum != {7'd0, res.computed_sum})
        else $error("mismatch reported on equal sums");

endmodule

bind tar_header_checksum_check_top tar_hcc_checker u_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .res   (result)
);

`default_nettype wire

>>> test/tar_header_checksum_check_top_tb.sv
// Self-checking testbench for the tar header checksum checker. It streams 512-byte
// headers and partial ones, predicts results from the byte transfers or the table,
// and checks every result. Depends on tar_hcc_pkg, both stream interfaces and the top.
`timescale 1ns / 1ps

module tar_header_checksum_check_top_tb;
    import tar_hcc_pkg::*;

    // Run limits and the length of the long receiver hold-off.
    localparam int unsigned CycleLimit = 6_000_000;
    localparam int unsigned HoldCycles = 8000;
    localparam int          RandBlocks = 40;
    localparam logic [9:0]  FullHdr    = 10'(BlockBytes);

    // How the body of a header is filled, and how its checksum field is written.
    typedef enum logic [2:0] {
        BODY_ZERO, BODY_FF, BODY_ASCII, BODY_RAND, BODY_SPARSE
    } body_e;
    typedef enum logic [2:0] {
        FLD_BODY,  // leave the body bytes in place
        FLD_TEXT,  // eight given characters
        FLD_STD,   // correct sum as six digits, NUL, space
        FLD_PAD,   // space, correct sum as six digits, NUL
        FLD_WIDE,  // correct sum as eight digits, no terminator
        FLD_OFF,   // slightly wrong sum in the six-digit form
        FLD_MIX    // random mix of digits, spaces and stop characters
    } field_e;

    // One header of the directed table.
    typedef struct packed {
        body_e        body;
        logic         set_first;
        logic [7:0]   first;
        field_e       fld;
        logic [63:0]  text;
        logic         mark;
        logic [9:0]   nbytes;
        logic         typed;
        result_item_t want;
    } hdr_row_t;

    // One byte transfer, with the typed result it closes when there is one.
    typedef struct packed {
        logic [7:0]   b;
        logic         start;
        logic         typed;
        result_item_t want;
    } hdr_byte_t;

    // Directed headers: body, set first, first, field, text, mark, bytes, typed, result.
    localparam hdr_row_t DirRows [18] = '{
        '{BODY_ZERO, 1'b0, 8'h00, FLD_BODY, 64'h0, 1'b1, FullHdr, 1'b1,
          '{StatusEndOfArc, 17'd256, 24'd0}},
        '{BODY_FF, 1'b0, 8'h00, FLD_BODY, 64'h0, 1'b1, FullHdr, 1'b1,
          '{StatusMismatch, 17'd128776, 24'd0}},
        '{BODY_FF, 1'b1, 8'h00, FLD_BODY, 64'h0, 1'b1, FullHdr, 1'b1,
          '{StatusLeadNul, 17'd128521, 24'd0}},
        '{BODY_ZERO, 1'b1, 8'h00, FLD_TEXT, {"0000000", 8'h00}, 1'b1, FullHdr, 1'b1,
          '{StatusLeadNul, 17'd256, 24'd0}},
        '{BODY_ZERO, 1'b1, 8'h01, FLD_BODY, 64'h0, 1'b1, FullHdr, 1'b1,
          '{StatusMismatch, 17'd257, 24'd0}},
        '{BODY_ZERO, 1'b1, 8'h61, FLD_TEXT, "        ", 1'b1, FullHdr, 1'b1,
          '{StatusMismatch, 17'd353, 24'd0}},
        '{BODY_ZERO, 1'b1, 8'h61, FLD_TEXT, "77777777", 1'b1, FullHdr, 1'b1,
          '{StatusMismatch, 17'd353, 24'hFFFFFF}},
        '{BODY_ASCII, 1'b1, 8'h75, FLD_STD, 64'h0, 1'b1, FullHdr, 1'b0, '0},
        '{BODY_ASCII, 1'b1, 8'h62, FLD_PAD, 64'h0, 1'b1, FullHdr, 1'b0, '0},
        '{BODY_RAND, 1'b1, 8'hA5, FLD_WIDE, 64'h0, 1'b1, FullHdr, 1'b0, '0},
        '{BODY_ASCII, 1'b1, 8'h64, FLD_TEXT, "\t0001234", 1'b1, FullHdr, 1'b0, '0},
        '{BODY_ASCII, 1'b1, 8'h64, FLD_TEXT, "  +12345", 1'b1, FullHdr, 1'b0, '0},
        '{BODY_ASCII, 1'b1, 8'h64, FLD_TEXT, {" -1234 ", 8'h00}, 1'b1, FullHdr, 1'b0, '0},
        '{BODY_ASCII, 1'b1, 8'h64, FLD_TEXT, "  01238 ", 1'b1, FullHdr, 1'b0, '0},
        '{BODY_ASCII, 1'b1, 8'h66, FLD_STD, 64'h0, 1'b0, FullHdr, 1'b0, '0},
        '{BODY_ASCII, 1'b1, 8'h66, FLD_STD, 64'h0, 1'b1, 10'd200, 1'b0, '0},
        '{BODY_RAND, 1'b1, 8'hA5, FLD_STD, 64'h0, 1'b1, FullHdr, 1'b0, '0},
        '{BODY_ZERO, 1'b0, 8'h00, FLD_BODY, 64'h0, 1'b0, FullHdr, 1'b1,
          '{StatusEndOfArc, 17'd256, 24'd0}}
    };

    logic clk;
    logic rst_n;

    tar_hcc_byte_if   hdr_if ();
    tar_hcc_result_if res_if ();

    tar_header_checksum_check_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .hdr    (hdr_if),
        .result (res_if)
    );

    // Stimulus and expectation stores.
    hdr_byte_t    header_bytes_q [$];
    result_item_t pending_results [$];
    hdr_byte_t    cur_item;
    logic [7:0]   hdr_img [512];

    int unsigned items_pushed;
    int unsigned items_taken;
    int unsigned results_seen;
    int unsigned err_cnt;
    int unsigned cycle_cnt;
    bit          byte_taken;
    bit          hold_off;
    bit          calm;

    // Predictor state for the header in progress.
    logic [PosWidth-1:0] hdr_pos;
    logic [SumWidth-1:0] hdr_sum;
    logic [CkWidth-1:0]  hdr_ck;
    logic [1:0]          ck_phase;
    logic                lead_nul;
    logic                blk_zero;

    task automatic clear_header_state();
        hdr_pos  = '0;
        hdr_sum  = '0;
        hdr_ck   = '0;
        ck_phase = PhaseSkip;
        lead_nul = 1'b0;
        blk_zero = 1'b1;
    endtask

    // Adds one transferred byte to the running header and yields a result after byte 511.
    task automatic absorb_byte(input logic [7:0] b, input logic start,
                               output logic block_done, output result_item_t res);
        logic is_digit;
        if (start)
        begin
            clear_header_state();
        end
        is_digit   = (b >= "0") && (b <= "7");
        block_done = 1'b0;
        res        = '0;
        if (hdr_pos == '0)
        begin
            lead_nul = (b == 8'h00);
        end
        if (b != 8'h00)
        begin
            blk_zero = 1'b0;
        end
        // Checksum field bytes count as spaces and feed the octal reader.
        if (hdr_pos >= CkFirst && hdr_pos <= CkLast)
        begin
            hdr_sum = hdr_sum + SumWidth'(SpaceByte);
            case (ck_phase)
                PhaseSkip:
                begin
                    if (b != SpaceByte)
                    begin
                        if (is_digit)
                        begin
                            hdr_ck   = CkWidth'(b[2:0]);
                            ck_phase = PhaseDigits;
                        end
                        else
                        begin
                            ck_phase = PhaseStop;
                        end
                    end
                end
                PhaseDigits:
                begin
                    if (is_digit)
                    begin
                        hdr_ck = {hdr_ck[CkWidth-4:0], b[2:0]};
                    end
                    else
                    begin
                        ck_phase = PhaseStop;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            hdr_sum = hdr_sum + SumWidth'(b);
        end
        // The last byte closes the header; otherwise the position moves on.
        if (hdr_pos != LastPos)
        begin
            hdr_pos = hdr_pos + 1'b1;
        end
        else
        begin
            block_done = 1'b1;
            if (blk_zero)
            begin
                res.status = StatusEndOfArc;
            end
            else if (lead_nul)
            begin
                res.status = StatusLeadNul;
            end
            else if (hdr_ck != CkWidth'(hdr_sum))
            begin
                res.status = StatusMismatch;
            end
            else
            begin
                res.status = StatusValid;
            end
            res.computed_sum    = hdr_sum;
            res.stored_checksum = hdr_ck;
            clear_header_state();
        end
    endtask

    // Gap length for either side: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic put_octal(input int unsigned value, input int off, input int ndig);
        for (int i = 0; i < ndig; i++)
        begin
            hdr_img[off + i] = 8'h30 + 8'((value >> (3 * (ndig - 1 - i))) & 7);
        end
    endtask

    // Builds one header image: body first, then the checksum field.
    task automatic make_header(input body_e body, input logic set_first,
                               input logic [7:0] first, input field_e fld,
                               input logic [63:0] text);
        int unsigned base;
        int          ck0;
        ck0 = int'(CkFirst);
        for (int i = 0; i < 512; i++)
        begin
            case (body)
                BODY_ZERO:  hdr_img[i] = 8'h00;
                BODY_FF:    hdr_img[i] = 8'hFF;
                BODY_ASCII: hdr_img[i] = ($urandom_range(0, 9) < 7) ?
                                         8'($urandom_range(32, 126)) : 8'h00;
                BODY_RAND:  hdr_img[i] = 8'($urandom_range(0, 255));
                default:    hdr_img[i] = ($urandom_range(0, 19) == 0) ?
                                         8'($urandom_range(0, 255)) : 8'h00;
            endcase
        end
        if (set_first)
        begin
            hdr_img[0] = first;
        end
        // The correct checksum counts the eight field bytes as spaces.
        base = 8 * 32;
        for (int i = 0; i < 512; i++)
        begin
            if (i < ck0 || i > int'(CkLast))
            begin
                base += hdr_img[i];
            end
        end
        case (fld)
            FLD_TEXT:
            begin
                for (int k = 0; k < 8; k++)
                begin
                    hdr_img[ck0 + k] = text[63 - 8 * k -: 8];
                end
            end
            FLD_STD, FLD_OFF:
            begin
                put_octal((fld == FLD_OFF) ? base + $urandom_range(1, 7) : base, ck0, 6);
                hdr_img[ck0 + 6] = 8'h00;
                hdr_img[ck0 + 7] = SpaceByte;
            end
            FLD_PAD:
            begin
                hdr_img[ck0] = SpaceByte;
                put_octal(base, ck0 + 1, 6);
                hdr_img[ck0 + 7] = 8'h00;
            end
            FLD_WIDE:
            begin
                put_octal(base, ck0, 8);
            end
            FLD_MIX:
            begin
                for (int k = 0; k < 8; k++)
                begin
                    case ($urandom_range(0, 9))
                        0:       hdr_img[ck0 + k] = SpaceByte;
                        1, 2, 3,
                        4:       hdr_img[ck0 + k] = 8'h30 + 8'($urandom_range(0, 7));
                        5:       hdr_img[ck0 + k] = $urandom_range(0, 1) ? "8" : "9";
                        6:       hdr_img[ck0 + k] = "\t";
                        7:       hdr_img[ck0 + k] = $urandom_range(0, 1) ? "+" : "-";
                        8:       hdr_img[ck0 + k] = 8'h00;
                        default: hdr_img[ck0 + k] = 8'($urandom_range(0, 255));
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Random header: mostly well-formed with a correct checksum, the rest broken.
    task automatic make_random_header();
        body_e       body;
        field_e      fld;
        logic        set_first;
        logic [7:0]  first;
        logic [63:0] text;
        int          r;
        r = $urandom_range(0, 99);
        body = (r < 50) ? BODY_ASCII : (r < 72) ? BODY_RAND :
               (r < 87) ? BODY_SPARSE : (r < 94) ? BODY_ZERO : BODY_FF;
        set_first = 1'b1;
        first = ($urandom_range(0, 99) < 8) ? 8'h00 : 8'($urandom_range(33, 126));
        text = $urandom_range(0, 1) ? "77777777" : "        ";
        r = $urandom_range(0, 99);
        fld = (r < 20) ? FLD_STD : (r < 37) ? FLD_PAD : (r < 55) ? FLD_WIDE :
              (r < 70) ? FLD_OFF : (r < 85) ? FLD_MIX : (r < 95) ? FLD_BODY : FLD_TEXT;
        // Zero bodies stay mostly zero so that end-of-archive blocks occur.
        if (body == BODY_ZERO)
        begin
            fld       = FLD_BODY;
            set_first = 1'($urandom_range(0, 1));
        end
        make_header(body, set_first, first, fld, text);
    endtask

    task automatic enqueue_block(input int nbytes, input logic mark, input logic typed,
                                 input result_item_t want);
        hdr_byte_t item;
        for (int i = 0; i < nbytes; i++)
        begin
            item.b     = hdr_img[i];
            item.start = mark && (i == 0);
            item.typed = typed && (i == 511);
            item.want  = want;
            header_bytes_q.push_back(item);
            items_pushed++;
        end
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Alternates between stretches with random idling and stretches without.
    initial
    begin : calm_toggle
        calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(200, 1500)) @(posedge clk);
            calm = ($urandom_range(0, 2) == 0);
        end
    end

    // Header byte sender: presents bytes at falling edges, with random gaps between them.
    initial
    begin : byte_sender
        int gap;
        gap = 0;
        hdr_if.valid       = 1'b0;
        hdr_if.header_byte = '0;
        hdr_if.block_start = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && !(hdr_if.valid && !byte_taken))
            begin
                if (gap > 0)
                begin
                    hdr_if.valid <= 1'b0;
                    gap--;
                end
                else if (header_bytes_q.size() > 0)
                begin
                    cur_item = header_bytes_q.pop_front();
                    hdr_if.valid       <= 1'b1;
                    hdr_if.header_byte <= cur_item.b;
                    hdr_if.block_start <= cur_item.start;
                    gap = pick_gap();
                end
                else
                begin
                    hdr_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, plus the long hold-off when it is active.
    initial
    begin : result_taker
        int stall;
        stall = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n || hold_off)
            begin
                res_if.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                res_if.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    // Long receiver hold-off once the random part is under way, so the block backs up.
    initial
    begin : long_hold
        hold_off = 1'b0;
        wait (results_seen >= 24);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_off = 1'b0;
    end

    // Transfer monitor: predicts on byte transfers and checks result transfers.
    always @(posedge clk)
    begin : xfer_monitor
        logic         block_done;
        result_item_t pred;
        result_item_t want;
        result_item_t got;
        byte_taken = hdr_if.valid && hdr_if.ready;
        if (rst_n && byte_taken)
        begin
            items_taken++;
            absorb_byte(cur_item.b, cur_item.start, block_done, pred);
            if (block_done)
            begin
                pending_results.push_back(cur_item.typed ? cur_item.want : pred);
            end
        end
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            got.status          = res_if.status;
            got.computed_sum    = res_if.computed_sum;
            got.stored_checksum = res_if.stored_checksum;
            if (pending_results.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                begin
                    $display("%0t: result with none expected: status %0d sum %0d ck %0o",
                             $realtime, got.status, got.computed_sum, got.stored_checksum);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.computed_sum !== want.computed_sum ||
                    got.stored_checksum !== want.stored_checksum)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                    begin
                        $display("%0t: result mismatch: exp status %0d sum %0d ck %0o, got status %0d sum %0d ck %0o",
                                 $realtime, want.status, want.computed_sum,
                                 want.stored_checksum, got.status, got.computed_sum,
                                 got.stored_checksum);
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CycleLimit)
        begin
            $display("tar_header_checksum_check_top_tb NOT OK");
            $finish;
        end
    end

    // Main sequence: build all headers, release reset, then drain and report.
    initial
    begin : main_seq
        logic need_mark;
        rst_n = 1'b0;
        clear_header_state();

        // Directed headers from the table.
        foreach (DirRows[r])
        begin
            make_header(DirRows[r].body, DirRows[r].set_first, DirRows[r].first,
                        DirRows[r].fld, DirRows[r].text);
            enqueue_block(DirRows[r].nbytes, DirRows[r].mark, DirRows[r].typed,
                          DirRows[r].want);
        end

        // Random headers; an abandoned partial header forces a start mark on the next one.
        for (int n = 0; n < RandBlocks; n++)
        begin
            need_mark = 1'b0;
            if ($urandom_range(0, 99) < 8)
            begin
                make_random_header();
                enqueue_block($urandom_range(1, 511), 1'($urandom_range(0, 1)), 1'b0, '0);
                need_mark = 1'b1;
            end
            make_random_header();
            enqueue_block(512, need_mark || ($urandom_range(0, 99) < 80), 1'b0, '0);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (items_taken == items_pushed);
        wait (pending_results.size() == 0);
        repeat (20) @(posedge clk);
        if (err_cnt == 0 && pending_results.size() == 0)
        begin
            $display("tar_header_checksum_check_top_tb OK");
        end
        else
        begin
            $display("tar_header_checksum_check_top_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
sv/tar_hcc_pkg.sv
sv/tar_hcc_byte_if.sv
sv/tar_hcc_result_if.sv
sv/tar_hcc_in_stage.sv
sv/tar_hcc_accum.sv
sv/tar_header_checksum_check_top.sv
sv/tar_hcc_checker.sv
test/tar_header_checksum_check_top_tb.sv
